FILE: hw/rtl/hse_pkg.sv
// shared types and constants of the heap sort engine
package hse_pkg;

  localparam int DATA_W              = 32;
  localparam int DEFAULT_STORE_DEPTH = 64;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

FILE: hw/rtl/hse_store.sv
// value store: one write port, two registered read ports
module hse_store #(
  parameter int STORE_DEPTH = hse_pkg::DEFAULT_STORE_DEPTH,
  parameter int AW          = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  hse_pkg::data_t    wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output hse_pkg::data_t    rd_data_a,
  output hse_pkg::data_t    rd_data_b
);

  hse_pkg::data_t mem [STORE_DEPTH];
  hse_pkg::data_t rd_a_r;
  hse_pkg::data_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

FILE: hw/rtl/heap_sort_engine.sv
// Heap sort engine: values are loaded one per cycle while busy is low (start high takes one
// request); a request with in_final_item set closes the set. Up to STORE_DEPTH values are kept,
// later ones are dropped and out_overflow_seen is set on every result of that set. The set is
// then heap sorted in place in a two-read, one-write store and read out in ascending order, one
// result per cycle on out_valid, with out_end_of_set on the last one; results cannot be stalled.
// The sort builds a max-heap by sifting down from each parent, last parent first, then moves the
// root to the tail and sifts the old tail value down from the root until one value is left; each
// level a sift-down visits (at most log2 n + 1 per sift) does one store read, compare and write.
// busy goes high after the closing request is taken and is low again in the cycle that carries
// the last result.
module heap_sort_engine #(
  parameter int STORE_DEPTH = hse_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hse_pkg::data_t in_sample_value,
  input  logic           in_final_item,
  output logic           out_valid,
  output hse_pkg::data_t out_sorted_value,
  output logic           out_end_of_set,
  output logic           out_overflow_seen
);

  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int CIW = AW + 2;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_BUILD_RD = 3'd1;
  localparam logic [2:0] S_BUILD_LD = 3'd2;
  localparam logic [2:0] S_SIFT     = 3'd3;
  localparam logic [2:0] S_EXT_RD   = 3'd4;
  localparam logic [2:0] S_EXT_LD   = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  function automatic logic [CIW-1:0] left_of(input logic [AW-1:0] p);
    left_of = {1'b0, p, 1'b1};
  endfunction

  function automatic logic [CIW-1:0] right_of(input logic [AW-1:0] p);
    right_of = left_of(p) + CIW'(1);
  endfunction

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           drop_r, drop_nxt;
  logic [CW-1:0]  hl_r, hl_nxt;
  logic [AW-1:0]  root_r, root_nxt;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic           extract_r, extract_nxt;
  hse_pkg::data_t v_r, v_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  hse_pkg::data_t wr_data;
  logic [AW-1:0]  rd_addr_a, rd_addr_b;
  hse_pkg::data_t rd_data_a, rd_data_b;

  logic           accept;
  logic           full;
  logic [CW-1:0]  fill_new;
  logic [CIW-1:0] lc, rc;
  logic           pick_l, pick_r;
  hse_pkg::data_t best_val;
  logic [AW-1:0]  child_pos;

  hse_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign accept   = start && (state_r == S_IDLE);
  assign full     = (fill_r == CW'(STORE_DEPTH));
  assign fill_new = full ? fill_r : fill_r + CW'(1);

  // children of the current hole; entries at or past the heap length are ignored
  assign lc       = left_of(pos_r);
  assign rc       = right_of(pos_r);
  assign pick_l   = (lc < CIW'(hl_r)) && (rd_data_a > v_r);
  assign best_val = pick_l ? rd_data_a : v_r;
  assign pick_r   = (rc < CIW'(hl_r)) && (rd_data_b > best_val);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    hl_nxt        = hl_r;
    root_nxt      = root_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    extract_nxt   = extract_r;
    v_nxt         = v_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_sample_value;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    child_pos     = pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          fill_nxt = fill_new;
          drop_nxt = drop_r | full;
          if (!full) begin
            wr_en   = 1'b1;
            wr_addr = fill_r[AW-1:0];
          end
          if (in_final_item) begin
            hl_nxt  = fill_new;
            idx_nxt = '0;
            if (fill_new < CW'(2)) begin
              state_nxt = S_OUT;
            end else begin
              root_nxt  = AW'((fill_new >> 1) - CW'(1));
              state_nxt = S_BUILD_RD;
            end
          end
        end
      end
      S_BUILD_RD: begin
        rd_addr_a = root_r;
        state_nxt = S_BUILD_LD;
      end
      S_BUILD_LD: begin
        v_nxt       = rd_data_a;
        pos_nxt     = root_r;
        hl_nxt      = fill_r;
        extract_nxt = 1'b0;
        child_pos   = root_r;
        rd_addr_a   = AW'(left_of(child_pos));
        rd_addr_b   = AW'(right_of(child_pos));
        state_nxt   = S_SIFT;
      end
      S_SIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        if (pick_r || pick_l) begin
          // move the larger child up and follow it
          wr_data   = pick_r ? rd_data_b : rd_data_a;
          pos_nxt   = pick_r ? rc[AW-1:0] : lc[AW-1:0];
          child_pos = pos_nxt;
          rd_addr_a = AW'(left_of(child_pos));
          rd_addr_b = AW'(right_of(child_pos));
        end else begin
          wr_data = v_r;
          if (!extract_r) begin
            if (root_r == '0) begin
              k_nxt     = AW'(fill_r - CW'(1));
              state_nxt = S_EXT_RD;
            end else begin
              root_nxt  = root_r - AW'(1);
              state_nxt = S_BUILD_RD;
            end
          end else if (k_r == AW'(1)) begin
            idx_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            k_nxt     = k_r - AW'(1);
            state_nxt = S_EXT_RD;
          end
        end
      end
      S_EXT_RD: begin
        rd_addr_a = '0;
        rd_addr_b = k_r;
        state_nxt = S_EXT_LD;
      end
      S_EXT_LD: begin
        // root goes to the tail, old tail value sifts down from the root
        wr_en       = 1'b1;
        wr_addr     = k_r;
        wr_data     = rd_data_a;
        v_nxt       = rd_data_b;
        pos_nxt     = '0;
        hl_nxt      = CW'(k_r);
        extract_nxt = 1'b1;
        child_pos   = '0;
        rd_addr_a   = AW'(left_of(child_pos));
        rd_addr_b   = AW'(right_of(child_pos));
        state_nxt   = S_SIFT;
      end
      S_OUT: begin
        rd_addr_a     = idx_r;
        out_valid_nxt = 1'b1;
        out_ovf_nxt   = drop_r;
        if (CW'(idx_r) == fill_r - CW'(1)) begin
          out_last_nxt = 1'b1;
          fill_nxt     = '0;
          drop_nxt     = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hl_r      <= hl_nxt;
    root_r    <= root_nxt;
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    idx_r     <= idx_nxt;
    extract_r <= extract_nxt;
    v_r       <= v_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_sorted_value  = rd_data_a;
  assign out_end_of_set    = out_last_r;
  assign out_overflow_seen = out_ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_sift_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIFT) |-> (CW'(pos_r) < hl_r))
    else $error("sift position outside heap");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_set |-> out_valid)
    else $error("end of set without result");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_set |=> (!out_valid && fill_r == '0) || (fill_r == CW'(1)))
    else $error("set state not cleared after last result");

  a_results_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid)
    else $error("readout cycle without result");

endmodule
